>>> rtl/core/tprq_pkg.sv
`timescale 1ns / 1ps

package tprq_pkg;

    localparam int TPRQ_COORD_WIDTH  = 32;
    localparam int TPRQ_NORMAL_WIDTH = 16;

    localparam int FACES        = 4;
    localparam int NORMAL_REG_W = 48;
    localparam int OFFSET_REG_W = 64;
    localparam int HALF_TOL_W   = 32;
    localparam int CFG_DATA_W   = 64;
    localparam int CFG_INDEX_W  = 3;

    // quotient magnitudes saturate at 2^QBITS
    localparam int QBITS = 60;

    localparam logic [CFG_INDEX_W-1:0] CFG_FACE0_NORMAL = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FACE1_NORMAL = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_FACE2_NORMAL = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_FACE3_NORMAL = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_OFFSETS_LOW  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_OFFSETS_HIGH = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_HALF_TOL     = 3'd6;

    localparam logic [1:0] LOC_INSIDE  = 2'd0;
    localparam logic [1:0] LOC_SURFACE = 2'd1;
    localparam logic [1:0] LOC_OUTSIDE = 2'd2;

    typedef struct packed {
        logic [3:0] ent;
        logic [3:0] tcand;
        logic [3:0] cpos;
        logic [3:0] dneg;
        logic       miss;
        logic       exz;
        logic [1:0] exz_face;
        logic [1:0] loc;
        logic [3:0] mask;
        logic [1:0] nearest;
    } tprq_flags_t;

    function automatic int max_int(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

endpackage

>>> rtl/core/tprq_plane.sv
`timescale 1ns / 1ps

module tprq_plane #(
    parameter int COORD_WIDTH  = tprq_pkg::TPRQ_COORD_WIDTH,
    parameter int NORMAL_WIDTH = tprq_pkg::TPRQ_NORMAL_WIDTH
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    adv,
    input  logic                                    in_valid,
    input  logic signed [COORD_WIDTH-1:0]           point_x,
    input  logic signed [COORD_WIDTH-1:0]           point_y,
    input  logic signed [COORD_WIDTH-1:0]           point_z,
    input  logic signed [NORMAL_WIDTH-1:0]          dir_x,
    input  logic signed [NORMAL_WIDTH-1:0]          dir_y,
    input  logic signed [NORMAL_WIDTH-1:0]          dir_z,
    input  logic [3:0][2:0][NORMAL_WIDTH-1:0]       normal,
    input  logic [3:0][COORD_WIDTH-1:0]             offset,
    input  logic [tprq_pkg::HALF_TOL_W-1:0]         half_tol,
    output logic                                    valid,
    output logic [3:0][COORD_WIDTH+4:0]             dist_mag,
    output logic [3:0][2*NORMAL_WIDTH+1:0]          cos_mag,
    output tprq_pkg::tprq_flags_t                   flags,
    output logic [COORD_WIDTH-1:0]                  safety_in,
    output logic [COORD_WIDTH-1:0]                  safety_out
);
    import tprq_pkg::*;

    localparam int NF   = NORMAL_WIDTH - 2;
    localparam int PW   = COORD_WIDTH + NORMAL_WIDTH;
    localparam int SW   = PW + 2;
    localparam int DW   = COORD_WIDTH + 5;
    localparam int CPW  = 2 * NORMAL_WIDTH;
    localparam int CSW  = CPW + 2;
    localparam int CMPW = max_int(DW, HALF_TOL_W + 1) + 1;

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;

    logic signed [COORD_WIDTH-1:0]  pt [0:2];
    logic signed [NORMAL_WIDTH-1:0] dv [0:2];

    logic signed [PW-1:0]  pp_reg [0:3][0:2];
    logic signed [CPW-1:0] cp_reg [0:3][0:2];
    logic signed [SW-1:0]  s_reg  [0:3];
    logic signed [CSW-1:0] cs_reg [0:3];
    logic signed [DW-1:0]  d3_reg [0:3];
    logic signed [CSW-1:0] c3_reg [0:3];

    logic signed [CMPW-1:0] tpos, tneg;
    logic signed [CMPW-1:0] dx [0:3];

    logic [3:0]           ge_reg, le_reg, cneg_reg, cpos_reg, dneg_reg;
    logic [DW-1:0]        dmag_reg [0:3];
    logic [CSW-1:0]       cmag_reg [0:3];
    logic signed [DW-1:0] mx01_reg, mx23_reg;
    logic                 i01_reg, i23_reg;

    logic signed [DW-1:0]  dmax;
    logic signed [DW:0]    nd;
    logic [1:0]            near_next;
    logic [3:0]            exz_set;
    tprq_flags_t           flags_next;
    tprq_flags_t           flags_reg;
    logic [COORD_WIDTH-1:0] safety_in_next, safety_out_next;
    logic [COORD_WIDTH-1:0] safety_in_reg, safety_out_reg;
    logic [DW-1:0]         dmag5_reg [0:3];
    logic [CSW-1:0]        cmag5_reg [0:3];

    assign pt[0] = point_x;
    assign pt[1] = point_y;
    assign pt[2] = point_z;
    assign dv[0] = dir_x;
    assign dv[1] = dir_y;
    assign dv[2] = dir_z;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    // products, sums, plane distance
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 4; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    pp_reg[i][j] <= $signed(normal[i][j]) * pt[j];
                    cp_reg[i][j] <= $signed(normal[i][j]) * dv[j];
                end
                s_reg[i]  <= pp_reg[i][0] + pp_reg[i][1] + pp_reg[i][2];
                cs_reg[i] <= cp_reg[i][0] + cp_reg[i][1] + cp_reg[i][2];
                d3_reg[i] <= DW'(s_reg[i] >>> NF) - DW'($signed(offset[i]));
                c3_reg[i] <= cs_reg[i];
            end
        end
    end

    assign tpos = CMPW'({1'b0, half_tol});
    assign tneg = -tpos;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            dx[i] = CMPW'(d3_reg[i]);
        end
    end

    // tolerance compares, magnitudes, first max pair
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 4; i++)
            begin
                ge_reg[i]   <= dx[i] >= tneg;
                le_reg[i]   <= dx[i] <= tpos;
                cneg_reg[i] <= c3_reg[i][CSW-1];
                cpos_reg[i] <= !c3_reg[i][CSW-1] && (c3_reg[i] != '0);
                dneg_reg[i] <= d3_reg[i][DW-1];
                dmag_reg[i] <= d3_reg[i][DW-1] ? DW'(-d3_reg[i]) : DW'(d3_reg[i]);
                cmag_reg[i] <= c3_reg[i][CSW-1] ? CSW'(-c3_reg[i]) : CSW'(c3_reg[i]);
            end
            i01_reg  <= d3_reg[1] > d3_reg[0];
            mx01_reg <= (d3_reg[1] > d3_reg[0]) ? d3_reg[1] : d3_reg[0];
            i23_reg  <= d3_reg[3] > d3_reg[2];
            mx23_reg <= (d3_reg[3] > d3_reg[2]) ? d3_reg[3] : d3_reg[2];
        end
    end

    always_comb
    begin
        dmax      = (mx23_reg > mx01_reg) ? mx23_reg : mx01_reg;
        near_next = (mx23_reg > mx01_reg) ? {1'b1, i23_reg} : {1'b0, i01_reg};
        nd        = -((DW+1)'(dmax));
        exz_set   = ge_reg & cpos_reg;

        flags_next.ent   = ge_reg & cneg_reg;
        flags_next.tcand = ~ge_reg & cpos_reg;
        flags_next.cpos  = cpos_reg;
        flags_next.dneg  = dneg_reg;
        flags_next.miss  = |(ge_reg & ~cneg_reg);
        flags_next.exz   = |exz_set;
        if (exz_set[0])
        begin
            flags_next.exz_face = 2'd0;
        end
        else if (exz_set[1])
        begin
            flags_next.exz_face = 2'd1;
        end
        else if (exz_set[2])
        begin
            flags_next.exz_face = 2'd2;
        end
        else
        begin
            flags_next.exz_face = 2'd3;
        end
        if (CMPW'(dmax) <= tneg)
        begin
            flags_next.loc = LOC_INSIDE;
        end
        else if (CMPW'(dmax) <= tpos)
        begin
            flags_next.loc = LOC_SURFACE;
        end
        else
        begin
            flags_next.loc = LOC_OUTSIDE;
        end
        flags_next.mask    = ge_reg & le_reg;
        flags_next.nearest = near_next;

        if (dmax[DW-1])
        begin
            safety_in_next = '0;
        end
        else if (|dmax[DW-2:COORD_WIDTH])
        begin
            safety_in_next = '1;
        end
        else
        begin
            safety_in_next = dmax[COORD_WIDTH-1:0];
        end

        if (nd[DW])
        begin
            safety_out_next = '0;
        end
        else if (|nd[DW-1:COORD_WIDTH])
        begin
            safety_out_next = '1;
        end
        else
        begin
            safety_out_next = nd[COORD_WIDTH-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            flags_reg      <= flags_next;
            safety_in_reg  <= safety_in_next;
            safety_out_reg <= safety_out_next;
            for (int i = 0; i < 4; i++)
            begin
                dmag5_reg[i] <= dmag_reg[i];
                cmag5_reg[i] <= cmag_reg[i];
            end
        end
    end

    assign valid      = v5_reg;
    assign flags      = flags_reg;
    assign safety_in  = safety_in_reg;
    assign safety_out = safety_out_reg;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            dist_mag[i] = dmag5_reg[i];
            cos_mag[i]  = cmag5_reg[i];
        end
    end

endmodule

>>> rtl/core/tprq_divider.sv
`timescale 1ns / 1ps

module tprq_divider #(
    parameter int NUM_W     = 37,
    parameter int DEN_W     = 34,
    parameter int FRAC_BITS = 28,
    parameter int SIDE_W    = 64
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              adv,
    input  logic                              in_valid,
    input  logic [3:0][NUM_W-1:0]             num,
    input  logic [3:0][DEN_W-1:0]             den,
    input  tprq_pkg::tprq_flags_t             in_flags,
    input  logic [SIDE_W-1:0]                 in_side,
    output logic                              out_valid,
    output logic [3:0][tprq_pkg::QBITS:0]     quo,
    output tprq_pkg::tprq_flags_t             out_flags,
    output logic [SIDE_W-1:0]                 out_side
);
    import tprq_pkg::*;

    localparam int SH = QBITS - FRAC_BITS;
    localparam int CW0 = max_int(NUM_W, DEN_W);

    logic                 valid_reg [0:QBITS];
    tprq_flags_t          flags_reg [0:QBITS];
    logic [SIDE_W-1:0]    side_reg  [0:QBITS];
    logic [NUM_W-1:0]     num_reg   [0:QBITS][0:3];
    logic [DEN_W-1:0]     den_reg   [0:QBITS][0:3];
    logic [DEN_W-1:0]     rem_reg   [0:QBITS][0:3];
    logic [QBITS-1:0]     q_reg     [0:QBITS][0:3];
    logic                 sat_reg   [0:QBITS][0:3];

    logic [NUM_W-1:0]     hi [0:3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s <= QBITS; s++)
            begin
                valid_reg[s] <= 1'b0;
            end
        end
        else if (adv)
        begin
            valid_reg[0] <= in_valid;
            for (int s = 1; s <= QBITS; s++)
            begin
                valid_reg[s] <= valid_reg[s-1];
            end
        end
    end

    always_comb
    begin
        for (int l = 0; l < 4; l++)
        begin
            hi[l] = num[l] >> SH;
        end
    end

    // overflow check and first remainder
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            flags_reg[0] <= in_flags;
            side_reg[0]  <= in_side;
            for (int l = 0; l < 4; l++)
            begin
                num_reg[0][l] <= num[l];
                den_reg[0][l] <= den[l];
                sat_reg[0][l] <= CW0'(hi[l]) >= CW0'(den[l]);
                rem_reg[0][l] <= DEN_W'(hi[l]);
                q_reg[0][l]   <= '0;
            end
        end
    end

    // one quotient bit per stage
    for (genvar s = 1; s <= QBITS; s++)
    begin : g_stage
        localparam int K = QBITS - s;
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                flags_reg[s] <= flags_reg[s-1];
                side_reg[s]  <= side_reg[s-1];
            end
        end
        for (genvar l = 0; l < 4; l++)
        begin : g_lane
            logic           nb;
            logic [DEN_W:0] r2;
            logic [DEN_W:0] diff;
            logic           take;
            if ((K >= FRAC_BITS) && (K - FRAC_BITS < NUM_W))
            begin : g_bit
                assign nb = num_reg[s-1][l][K-FRAC_BITS];
            end
            else
            begin : g_zero
                assign nb = 1'b0;
            end
            assign r2   = {rem_reg[s-1][l], nb};
            assign take = r2 >= {1'b0, den_reg[s-1][l]};
            assign diff = r2 - {1'b0, den_reg[s-1][l]};
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    num_reg[s][l] <= num_reg[s-1][l];
                    den_reg[s][l] <= den_reg[s-1][l];
                    sat_reg[s][l] <= sat_reg[s-1][l];
                    rem_reg[s][l] <= take ? diff[DEN_W-1:0] : r2[DEN_W-1:0];
                    q_reg[s][l]   <= {q_reg[s-1][l][QBITS-2:0], take};
                end
            end
        end
    end

    always_comb
    begin
        for (int l = 0; l < 4; l++)
        begin
            quo[l] = sat_reg[QBITS][l] ? {1'b1, {QBITS{1'b0}}} : {1'b0, q_reg[QBITS][l]};
        end
    end

    assign out_valid = valid_reg[QBITS];
    assign out_flags = flags_reg[QBITS];
    assign out_side  = side_reg[QBITS];

endmodule

>>> rtl/core/tprq_resolve.sv
`timescale 1ns / 1ps

module tprq_resolve #(
    parameter int COORD_WIDTH = tprq_pkg::TPRQ_COORD_WIDTH
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic [3:0][tprq_pkg::QBITS:0]     quo,
    input  tprq_pkg::tprq_flags_t             in_flags,
    input  logic [2*COORD_WIDTH-1:0]          in_side,
    input  logic [tprq_pkg::HALF_TOL_W-1:0]   half_tol,
    input  logic                              out_ready,
    output logic                              adv,
    output logic                              out_valid,
    output logic [1:0]                        location,
    output logic [COORD_WIDTH-1:0]            safety_in,
    output logic [COORD_WIDTH-1:0]            safety_out,
    output logic [COORD_WIDTH-1:0]            entry_distance,
    output logic                              entry_hit,
    output logic [COORD_WIDTH-1:0]            exit_distance,
    output logic [1:0]                        exit_face,
    output logic [3:0]                        surface_mask,
    output logic [1:0]                        nearest_face
);
    import tprq_pkg::*;

    localparam int TS  = QBITS + 3;
    localparam int EXW = QBITS + 2;
    localparam logic signed [TS-1:0] T_INF  = {2'b01, {(QBITS+1){1'b0}}};
    localparam logic signed [TS-1:0] T_NINF = -T_INF;
    localparam logic [EXW-1:0]       EX_INF = {1'b1, {(QBITS+1){1'b0}}};

    logic v1_reg, v2_reg;
    logic out_load;

    logic signed [TS-1:0] qs     [0:3];
    logic signed [TS-1:0] tin_c  [0:3];
    logic signed [TS-1:0] tout_c [0:3];
    logic [EXW-1:0]       ex_c   [0:3];

    logic signed [TS-1:0] tin01_reg, tin23_reg, tout01_reg, tout23_reg;
    logic [EXW-1:0]       ex01_reg, ex23_reg;
    logic                 e01_reg, e23_reg;
    tprq_flags_t          flags1_reg, flags2_reg;
    logic [2*COORD_WIDTH-1:0] side1_reg, side2_reg;

    logic signed [TS-1:0] tin_reg, tout_reg;
    logic [EXW-1:0]       ex_reg;
    logic [1:0]           exf_reg;

    logic signed [TS:0]   tv, diff;
    logic                 miss, found;
    logic [COORD_WIDTH-1:0] entry_next, exit_next;
    logic [1:0]           exit_face_next;

    logic                   out_valid_reg;
    logic [1:0]             location_reg, exit_face_reg, nearest_reg;
    logic [COORD_WIDTH-1:0] safety_in_reg, safety_out_reg, entry_reg, exit_reg;
    logic                   hit_reg;
    logic [3:0]             mask_reg;

    assign out_load = !out_valid_reg || out_ready;
    assign adv      = !v2_reg || out_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv)
            begin
                v1_reg <= in_valid;
                v2_reg <= v1_reg;
            end
            if (out_load)
            begin
                out_valid_reg <= v2_reg;
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            qs[i]     = {2'b00, quo[i]};
            tin_c[i]  = in_flags.ent[i] ? (in_flags.dneg[i] ? -qs[i] : qs[i]) : T_NINF;
            tout_c[i] = in_flags.tcand[i] ? qs[i] : T_INF;
            ex_c[i]   = in_flags.cpos[i] ? {1'b0, quo[i]} : EX_INF;
        end
    end

    // pairwise reduction, then final
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            tin01_reg  <= (tin_c[1] > tin_c[0]) ? tin_c[1] : tin_c[0];
            tin23_reg  <= (tin_c[3] > tin_c[2]) ? tin_c[3] : tin_c[2];
            tout01_reg <= (tout_c[1] < tout_c[0]) ? tout_c[1] : tout_c[0];
            tout23_reg <= (tout_c[3] < tout_c[2]) ? tout_c[3] : tout_c[2];
            e01_reg    <= ex_c[1] < ex_c[0];
            ex01_reg   <= (ex_c[1] < ex_c[0]) ? ex_c[1] : ex_c[0];
            e23_reg    <= ex_c[3] < ex_c[2];
            ex23_reg   <= (ex_c[3] < ex_c[2]) ? ex_c[3] : ex_c[2];
            flags1_reg <= in_flags;
            side1_reg  <= in_side;

            tin_reg    <= (tin23_reg > tin01_reg) ? tin23_reg : tin01_reg;
            tout_reg   <= (tout23_reg < tout01_reg) ? tout23_reg : tout01_reg;
            ex_reg     <= (ex23_reg < ex01_reg) ? ex23_reg : ex01_reg;
            exf_reg    <= (ex23_reg < ex01_reg) ? {1'b1, e23_reg} : {1'b0, e01_reg};
            flags2_reg <= flags1_reg;
            side2_reg  <= side1_reg;
        end
    end

    always_comb
    begin
        tv    = {{(TS+1-HALF_TOL_W){1'b0}}, half_tol};
        diff  = (TS+1)'(tout_reg) - (TS+1)'(tin_reg);
        miss  = flags2_reg.miss || (diff <= tv);
        found = |flags2_reg.cpos;

        if (miss)
        begin
            entry_next = '1;
        end
        else if ((TS+1)'(tin_reg) < tv)
        begin
            entry_next = '0;
        end
        else if (|tin_reg[TS-1:COORD_WIDTH])
        begin
            entry_next = '1;
        end
        else
        begin
            entry_next = tin_reg[COORD_WIDTH-1:0];
        end

        if (!found)
        begin
            exit_next      = '1;
            exit_face_next = 2'd0;
        end
        else if (flags2_reg.exz)
        begin
            exit_next      = '0;
            exit_face_next = flags2_reg.exz_face;
        end
        else
        begin
            exit_next      = (|ex_reg[EXW-1:COORD_WIDTH]) ? '1 : ex_reg[COORD_WIDTH-1:0];
            exit_face_next = exf_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            location_reg   <= flags2_reg.loc;
            safety_in_reg  <= side2_reg[2*COORD_WIDTH-1:COORD_WIDTH];
            safety_out_reg <= side2_reg[COORD_WIDTH-1:0];
            entry_reg      <= entry_next;
            hit_reg        <= !miss;
            exit_reg       <= exit_next;
            exit_face_reg  <= exit_face_next;
            mask_reg       <= flags2_reg.mask;
            nearest_reg    <= flags2_reg.nearest;
        end
    end

    assign out_valid      = out_valid_reg;
    assign location       = location_reg;
    assign safety_in      = safety_in_reg;
    assign safety_out     = safety_out_reg;
    assign entry_distance = entry_reg;
    assign entry_hit      = hit_reg;
    assign exit_distance  = exit_reg;
    assign exit_face      = exit_face_reg;
    assign surface_mask   = mask_reg;
    assign nearest_face   = nearest_reg;

endmodule

>>> rtl/core/tetrahedron_point_ray_query_unit.sv
`timescale 1ns / 1ps

// Point and ray queries against one tetrahedron held as four face planes. One item
// (point and unit direction) is accepted per cycle while in_ready is high. Each item passes
// through 69 register stages: 5 of plane products and tolerance compares, 61 in the four
// per-face restoring dividers (one quotient bit per stage, 60 bits plus an overflow check),
// and 3 of slab clipping and output formatting. While a result waits in the output register,
// the pipeline still advances until the next item reaches the stage in front of it.
// Face planes and the half tolerance are read live, so write them only while no item is in
// flight.

module tetrahedron_point_ray_query_unit #(
    parameter int COORD_WIDTH  = tprq_pkg::TPRQ_COORD_WIDTH,
    parameter int NORMAL_WIDTH = tprq_pkg::TPRQ_NORMAL_WIDTH
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write_en,
    input  logic [tprq_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [tprq_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [COORD_WIDTH-1:0]       point_x,
    input  logic signed [COORD_WIDTH-1:0]       point_y,
    input  logic signed [COORD_WIDTH-1:0]       point_z,
    input  logic signed [NORMAL_WIDTH-1:0]      dir_x,
    input  logic signed [NORMAL_WIDTH-1:0]      dir_y,
    input  logic signed [NORMAL_WIDTH-1:0]      dir_z,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [1:0]                          location,
    output logic [COORD_WIDTH-1:0]              safety_in,
    output logic [COORD_WIDTH-1:0]              safety_out,
    output logic [COORD_WIDTH-1:0]              entry_distance,
    output logic                                entry_hit,
    output logic [COORD_WIDTH-1:0]              exit_distance,
    output logic [1:0]                          exit_face,
    output logic [3:0]                          surface_mask,
    output logic [1:0]                          nearest_face
);
    import tprq_pkg::*;

    localparam int DW  = COORD_WIDTH + 5;
    localparam int CSW = 2 * NORMAL_WIDTH + 2;
    localparam int NF  = NORMAL_WIDTH - 2;

    logic [NORMAL_REG_W-1:0] face_normal_reg [0:3];
    logic [OFFSET_REG_W-1:0] offset_reg [0:1];
    logic [HALF_TOL_W-1:0]   half_tol_reg;

    logic [3:0][2:0][NORMAL_WIDTH-1:0] normal;
    logic [3:0][COORD_WIDTH-1:0]       offset;

    logic                    adv;
    logic                    pl_valid, dv_valid;
    logic [3:0][DW-1:0]      dist_mag;
    logic [3:0][CSW-1:0]     cos_mag;
    tprq_flags_t             pl_flags, dv_flags;
    logic [COORD_WIDTH-1:0]  pl_safety_in, pl_safety_out;
    logic [2*COORD_WIDTH-1:0] dv_side;
    logic [3:0][QBITS:0]     quo;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
            begin
                face_normal_reg[i] <= '0;
            end
            offset_reg[0] <= '0;
            offset_reg[1] <= '0;
            half_tol_reg  <= HALF_TOL_W'(1);
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                CFG_FACE0_NORMAL: face_normal_reg[0] <= cfg_data[NORMAL_REG_W-1:0];
                CFG_FACE1_NORMAL: face_normal_reg[1] <= cfg_data[NORMAL_REG_W-1:0];
                CFG_FACE2_NORMAL: face_normal_reg[2] <= cfg_data[NORMAL_REG_W-1:0];
                CFG_FACE3_NORMAL: face_normal_reg[3] <= cfg_data[NORMAL_REG_W-1:0];
                CFG_OFFSETS_LOW:  offset_reg[0] <= cfg_data[OFFSET_REG_W-1:0];
                CFG_OFFSETS_HIGH: offset_reg[1] <= cfg_data[OFFSET_REG_W-1:0];
                CFG_HALF_TOL:     half_tol_reg <= cfg_data[HALF_TOL_W-1:0];
                default:          ;
            endcase
        end
    end

    // fields beyond the register read as zero
    for (genvar gi = 0; gi < 4; gi++)
    begin : g_face
        logic [127:0] n_ext;
        logic [127:0] o_ext;
        assign n_ext = {{(128-NORMAL_REG_W){1'b0}}, face_normal_reg[gi]};
        assign o_ext = {{(128-OFFSET_REG_W){1'b0}}, offset_reg[gi/2]};
        for (genvar gj = 0; gj < 3; gj++)
        begin : g_comp
            assign normal[gi][gj] = n_ext[gj*NORMAL_WIDTH +: NORMAL_WIDTH];
        end
        assign offset[gi] = o_ext[(gi%2)*COORD_WIDTH +: COORD_WIDTH];
    end

    assign in_ready = adv;

    tprq_plane #(
        .COORD_WIDTH  (COORD_WIDTH),
        .NORMAL_WIDTH (NORMAL_WIDTH)
    ) u_plane (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .in_valid   (in_valid),
        .point_x    (point_x),
        .point_y    (point_y),
        .point_z    (point_z),
        .dir_x      (dir_x),
        .dir_y      (dir_y),
        .dir_z      (dir_z),
        .normal     (normal),
        .offset     (offset),
        .half_tol   (half_tol_reg),
        .valid      (pl_valid),
        .dist_mag   (dist_mag),
        .cos_mag    (cos_mag),
        .flags      (pl_flags),
        .safety_in  (pl_safety_in),
        .safety_out (pl_safety_out)
    );

    tprq_divider #(
        .NUM_W     (DW),
        .DEN_W     (CSW),
        .FRAC_BITS (2*NF),
        .SIDE_W    (2*COORD_WIDTH)
    ) u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (pl_valid),
        .num       (dist_mag),
        .den       (cos_mag),
        .in_flags  (pl_flags),
        .in_side   ({pl_safety_in, pl_safety_out}),
        .out_valid (dv_valid),
        .quo       (quo),
        .out_flags (dv_flags),
        .out_side  (dv_side)
    );

    tprq_resolve #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_resolve (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (dv_valid),
        .quo            (quo),
        .in_flags       (dv_flags),
        .in_side        (dv_side),
        .half_tol       (half_tol_reg),
        .out_ready      (out_ready),
        .adv            (adv),
        .out_valid      (out_valid),
        .location       (location),
        .safety_in      (safety_in),
        .safety_out     (safety_out),
        .entry_distance (entry_distance),
        .entry_hit      (entry_hit),
        .exit_distance  (exit_distance),
        .exit_face      (exit_face),
        .surface_mask   (surface_mask),
        .nearest_face   (nearest_face)
    );

    a_inside_no_safety_in: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (location == LOC_INSIDE) |-> (safety_in == '0))
        else $error("inside point with nonzero safety_in");

    a_outside_no_safety_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (location == LOC_OUTSIDE) |-> (safety_out == '0))
        else $error("outside point with nonzero safety_out");

    a_miss_saturates: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !entry_hit |-> (entry_distance == '1))
        else $error("entry miss without saturated distance");

    a_ready_with_room: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output register");

endmodule

>>> tb/tetrahedron_point_ray_query_unit_tb.sv
`timescale 1ns / 1ps

module tetrahedron_point_ray_query_unit_tb;

    import tprq_pkg::*;

    localparam longint QMAX = longint'(1) << 60;
    localparam longint TINF = longint'(1) << 61;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int HOLD_CYCLES = 300;

    typedef struct packed {
        logic [1:0]  location;
        logic [31:0] safety_in;
        logic [31:0] safety_out;
        logic [31:0] entry_distance;
        logic        entry_hit;
        logic [31:0] exit_distance;
        logic [1:0]  exit_face;
        logic [3:0]  surface_mask;
        logic [1:0]  nearest_face;
    } query_result_t;

    class query_scoreboard;
        logic [47:0] normal_reg[4];
        logic [63:0] offset_reg[2];
        logic [31:0] half_tol;
        query_result_t pending[$];
        int errors;

        function new();
            errors = 0;
            reset_regs();
        endfunction

        function void reset_regs();
            for (int i = 0; i < 4; i++)
                normal_reg[i] = '0;
            offset_reg[0] = '0;
            offset_reg[1] = '0;
            half_tol = 32'd1;
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [63:0] data);
            case (idx)
                CFG_FACE0_NORMAL, CFG_FACE1_NORMAL, CFG_FACE2_NORMAL, CFG_FACE3_NORMAL:
                    normal_reg[idx[1:0]] = data[47:0];
                CFG_OFFSETS_LOW:  offset_reg[0] = data;
                CFG_OFFSETS_HIGH: offset_reg[1] = data;
                CFG_HALF_TOL:     half_tol = data[31:0];
                default: ;
            endcase
        endfunction

        function bit [63:0] magnitude(longint x);
            return (x < 0) ? bit'(0) - x : x;
        endfunction

        // floor(num * 2^28 / den) with saturation
        function longint ray_quotient(bit [63:0] num, bit [63:0] den);
            bit [63:0] q;
            bit [63:0] r;
            if (den == 0)
                return QMAX;
            q = num / den;
            r = num % den;
            if (q >= QMAX)
                return QMAX;
            for (int i = 0; i < 28; i++)
            begin
                if (q >= QMAX / 2)
                    return QMAX;
                q = q << 1;
                r = r << 1;
                if (r >= den)
                begin
                    r = r - den;
                    q = q + 1;
                end
            end
            return longint'(q);
        endfunction

        function logic [31:0] clamp_distance(longint x);
            if (x < 0)
                return 32'd0;
            if (x > longint'(32'hFFFF_FFFF))
                return 32'hFFFF_FFFF;
            return x[31:0];
        endfunction

        function query_result_t predict_query(logic signed [31:0] pt[3],
                                              logic signed [15:0] dr[3]);
            query_result_t res;
            longint plane_d[4];
            longint cosv[4];
            longint t;
            longint dmax;
            longint smin;
            longint tin;
            longint tout;
            longint ex;
            longint q;
            longint hi;
            longint lo;
            longint cs;
            longint n;
            longint bl;
            longint bh;
            longint ofs;
            bit miss;
            bit exit_found;
            bit exit_zero;
            logic [3:0] mask;
            logic [1:0] near_idx;
            logic [1:0] ex_face;
            t = longint'(half_tol);
            tin = -TINF;
            tout = TINF;
            ex = TINF;
            miss = 0;
            exit_found = 0;
            exit_zero = 0;
            mask = '0;
            near_idx = '0;
            ex_face = '0;
            for (int i = 0; i < 4; i++)
            begin
                hi = 0;
                lo = 0;
                cs = 0;
                for (int j = 0; j < 3; j++)
                begin
                    n = longint'($signed(normal_reg[i][16*j +: 16]));
                    bl = longint'(pt[j]) & 64'hFF_FFFF;
                    bh = (longint'(pt[j]) - bl) >>> 24;
                    hi += n * bh;
                    lo += n * bl;
                    cs += n * longint'(dr[j]);
                end
                ofs = longint'($signed(offset_reg[i >> 1][32*(i & 1) +: 32]));
                plane_d[i] = hi * 1024 + (lo >>> 14) - ofs;
                cosv[i] = cs;
            end

            dmax = plane_d[0];
            smin = -plane_d[0];
            for (int i = 0; i < 4; i++)
            begin
                if (plane_d[i] > dmax)
                begin
                    dmax = plane_d[i];
                    near_idx = i[1:0];
                end
                if (-plane_d[i] < smin)
                    smin = -plane_d[i];
                if (plane_d[i] <= t && plane_d[i] >= -t)
                    mask[i] = 1'b1;
            end

            // slab clipping for entry
            for (int i = 0; i < 4; i++)
            begin
                if (plane_d[i] >= -t)
                begin
                    if (cosv[i] >= 0)
                        miss = 1;
                    else
                    begin
                        q = ray_quotient(magnitude(plane_d[i]), magnitude(cosv[i]));
                        if (plane_d[i] < 0)
                            q = -q;
                        if (q > tin)
                            tin = q;
                    end
                end
                else if (cosv[i] > 0)
                begin
                    q = ray_quotient(magnitude(plane_d[i]), cosv[i]);
                    if (q < tout)
                        tout = q;
                end
            end
            if (!miss && tout - tin <= t)
                miss = 1;

            // first leaving face
            for (int i = 0; i < 4; i++)
            begin
                if (cosv[i] > 0 && !exit_zero)
                begin
                    if (plane_d[i] >= -t)
                    begin
                        ex = 0;
                        ex_face = i[1:0];
                        exit_found = 1;
                        exit_zero = 1;
                    end
                    else
                    begin
                        q = ray_quotient(magnitude(plane_d[i]), cosv[i]);
                        if (q < ex)
                        begin
                            ex = q;
                            ex_face = i[1:0];
                            exit_found = 1;
                        end
                    end
                end
            end

            if (dmax <= -t)
                res.location = LOC_INSIDE;
            else if (dmax <= t)
                res.location = LOC_SURFACE;
            else
                res.location = LOC_OUTSIDE;
            res.safety_in = clamp_distance(dmax);
            res.safety_out = clamp_distance(smin);
            res.entry_distance = miss ? 32'hFFFF_FFFF : ((tin < t) ? 32'd0 : clamp_distance(tin));
            res.entry_hit = !miss;
            res.exit_distance = exit_found ? clamp_distance(ex) : 32'hFFFF_FFFF;
            res.exit_face = exit_found ? ex_face : 2'd0;
            res.surface_mask = mask;
            res.nearest_face = near_idx;
            return res;
        endfunction

        function void note_query(logic signed [31:0] pt[3], logic signed [15:0] dr[3]);
            pending.push_back(predict_query(pt, dr));
        endfunction

        task report(string msg);
            $display("mismatch at %0t: %s", $time, msg);
            errors++;
        endtask

        task check_result(query_result_t got);
            query_result_t want;
            if (pending.size() == 0)
            begin
                report("result with no item outstanding");
                return;
            end
            want = pending.pop_front();
            if (got.location !== want.location)
                report($sformatf("location %0d want %0d", got.location, want.location));
            if (got.safety_in !== want.safety_in)
                report($sformatf("safety_in %h want %h", got.safety_in, want.safety_in));
            if (got.safety_out !== want.safety_out)
                report($sformatf("safety_out %h want %h", got.safety_out, want.safety_out));
            if (got.entry_distance !== want.entry_distance)
                report($sformatf("entry_distance %h want %h",
                                 got.entry_distance, want.entry_distance));
            if (got.entry_hit !== want.entry_hit)
                report($sformatf("entry_hit %b want %b", got.entry_hit, want.entry_hit));
            if (got.exit_distance !== want.exit_distance)
                report($sformatf("exit_distance %h want %h",
                                 got.exit_distance, want.exit_distance));
            if (got.exit_face !== want.exit_face)
                report($sformatf("exit_face %0d want %0d", got.exit_face, want.exit_face));
            if (got.surface_mask !== want.surface_mask)
                report($sformatf("surface_mask %h want %h",
                                 got.surface_mask, want.surface_mask));
            if (got.nearest_face !== want.nearest_face)
                report($sformatf("nearest_face %0d want %0d",
                                 got.nearest_face, want.nearest_face));
        endtask
    endclass

    logic clk;
    logic rst_n;
    logic cfg_write_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic in_valid;
    logic in_ready;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;
    logic out_valid;
    logic out_ready;
    logic [1:0] location;
    logic [31:0] safety_in;
    logic [31:0] safety_out;
    logic [31:0] entry_distance;
    logic entry_hit;
    logic [31:0] exit_distance;
    logic [1:0] exit_face;
    logic [3:0] surface_mask;
    logic [1:0] nearest_face;

    query_scoreboard sb;
    bit idle_on;
    bit hold_req;
    bit hold_done;
    int quiet_cycles;

    tetrahedron_point_ray_query_unit dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_write_en(cfg_write_en),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .point_x(point_x),
        .point_y(point_y),
        .point_z(point_z),
        .dir_x(dir_x),
        .dir_y(dir_y),
        .dir_z(dir_z),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .location(location),
        .safety_in(safety_in),
        .safety_out(safety_out),
        .entry_distance(entry_distance),
        .entry_hit(entry_hit),
        .exit_distance(exit_distance),
        .exit_face(exit_face),
        .surface_mask(surface_mask),
        .nearest_face(nearest_face)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // receiver side
    initial
    begin
        out_ready = 1'b0;
        hold_done = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req && !hold_done)
            begin
                hold_done = 1;
                out_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            out_ready = !(idle_on && $urandom_range(99) < 23);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result({location, safety_in, safety_out, entry_distance, entry_hit,
                             exit_distance, exit_face, surface_mask, nearest_face});
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL tetrahedron_point_ray_query_unit");
            $finish;
        end
    end

    task send_query(logic signed [31:0] px, logic signed [31:0] py, logic signed [31:0] pz,
                    logic signed [15:0] dx, logic signed [15:0] dy, logic signed [15:0] dz);
        logic signed [31:0] pt[3];
        logic signed [15:0] dr[3];
        @(negedge clk);
        while (idle_on && $urandom_range(99) < 23)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        point_x = px;
        point_y = py;
        point_z = pz;
        dir_x = dx;
        dir_y = dy;
        dir_z = dz;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pt[0] = px;
        pt[1] = py;
        pt[2] = pz;
        dr[0] = dx;
        dr[1] = dy;
        dr[2] = dz;
        sb.note_query(pt, dr);
    endtask

    task wait_drain();
        @(negedge clk);
        in_valid = 1'b0;
        while (sb.pending.size() != 0)
            @(negedge clk);
        repeat (80) @(negedge clk);
    endtask

    task write_reg(logic [CFG_INDEX_W-1:0] idx, logic [63:0] data);
        @(negedge clk);
        cfg_write_en = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        sb.write_reg(idx, data);
        @(negedge clk);
        cfg_write_en = 1'b0;
    endtask

    task load_planes(logic [47:0] n0, logic [47:0] n1, logic [47:0] n2, logic [47:0] n3,
                     logic [63:0] offs_lo, logic [63:0] offs_hi, logic [31:0] tol);
        write_reg(CFG_FACE0_NORMAL, {16'h0, n0});
        write_reg(CFG_FACE1_NORMAL, {16'h0, n1});
        write_reg(CFG_FACE2_NORMAL, {16'h0, n2});
        write_reg(CFG_FACE3_NORMAL, {16'h0, n3});
        write_reg(CFG_OFFSETS_LOW, offs_lo);
        write_reg(CFG_OFFSETS_HIGH, offs_hi);
        write_reg(CFG_HALF_TOL, {32'h0, tol});
    endtask

    function logic signed [15:0] rand_dir_comp();
        return 16'($signed($urandom_range(32768)) - 16384);
    endfunction

    // point near the corner tetrahedron, sometimes snapped onto a face plane
    function logic signed [31:0] rand_near_coord(int unsigned span_mm);
        int v;
        v = $urandom_range(span_mm * 65536) - 40 * 65536;
        if ($urandom_range(7) == 0)
            v = $urandom_range(4) - 2;
        return v;
    endfunction

    task send_shaped(int count, int unsigned span_mm);
        for (int k = 0; k < count; k++)
        begin
            if ($urandom_range(9) == 0)
                send_query($urandom, $urandom, $urandom,
                           rand_dir_comp(), rand_dir_comp(), rand_dir_comp());
            else
                send_query(rand_near_coord(span_mm), rand_near_coord(span_mm),
                           rand_near_coord(span_mm),
                           rand_dir_comp(), rand_dir_comp(), rand_dir_comp());
        end
    endtask

    task send_noise(int count);
        for (int k = 0; k < count; k++)
        begin
            case ($urandom_range(3))
                0: send_query(32'sh7FFF_FFFF, 32'sh8000_0000, $urandom,
                              16'sd16384, -16'sd16384, rand_dir_comp());
                default: send_query($urandom, $urandom, $urandom,
                                    rand_dir_comp(), rand_dir_comp(), rand_dir_comp());
            endcase
        end
    endtask

    localparam logic [47:0] NEG_X = {16'sd0, 16'sd0, -16'sd16384};
    localparam logic [47:0] NEG_Y = {16'sd0, -16'sd16384, 16'sd0};
    localparam logic [47:0] NEG_Z = {-16'sd16384, 16'sd0, 16'sd0};
    localparam logic [47:0] DIAG = {16'sd9459, 16'sd9459, 16'sd9459};
    localparam int MM = 65536;

    initial
    begin
        sb = new();
        idle_on = 1;
        hold_req = 0;
        rst_n = 1'b0;
        cfg_write_en = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        point_x = '0;
        point_y = '0;
        point_z = '0;
        dir_x = '0;
        dir_y = '0;
        dir_z = '0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        // zero normals and offsets after reset
        send_query(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd0, 16'sd0, 16'sd0, 16'sd0);
        send_query(32'sd0, 32'sd0, 32'sd0, 16'sd16384, -16'sd16384, 16'sd16384);
        wait_drain();

        // corner tetrahedron of edge 100 mm
        load_planes(NEG_X, NEG_Y, NEG_Z, DIAG, 64'h0, {32'd3783740, 32'd0}, 32'd1);
        send_query(10 * MM, 10 * MM, 10 * MM, 16'sd16384, 16'sd0, 16'sd0);
        send_query(10 * MM, 10 * MM, 10 * MM, -16'sd16384, 16'sd0, 16'sd0);
        send_query(10 * MM, 10 * MM, 10 * MM, 16'sd0, 16'sd0, 16'sd0);
        send_query(0, 0, 0, 16'sd9459, 16'sd9459, 16'sd9459);
        send_query(0, 0, 0, -16'sd9459, -16'sd9459, -16'sd9459);
        send_query(1, 0, 0, 16'sd0, 16'sd16384, 16'sd0);
        send_query(-50 * MM, 20 * MM, 20 * MM, 16'sd16384, 16'sd0, 16'sd0);
        send_query(-50 * MM, 20 * MM, 20 * MM, -16'sd16384, 16'sd0, 16'sd0);
        send_query(-50 * MM, 200 * MM, 20 * MM, 16'sd16384, 16'sd0, 16'sd0);
        send_query(200 * MM, 200 * MM, 200 * MM, -16'sd9459, -16'sd9459, -16'sd9459);
        send_query(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                   -16'sd16384, -16'sd16384, -16'sd16384);
        send_query(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                   16'sd16384, 16'sd16384, 16'sd16384);
        send_query(50 * MM, 0, 0, 16'sd0, 16'sd0, 16'sd16384);
        send_query(-1, -1, -1, 16'sd0, 16'sd0, -16'sd16384);
        send_query(20 * MM, 20 * MM, -10 * MM, 16'sd0, 16'sd0, 16'sd16384);
        send_shaped(100, 180);
        hold_req = 1;
        send_shaped(160, 180);
        wait_drain();
        send_shaped(40, 180);
        wait_drain();

        // random planes, zero tolerance
        load_planes(48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
                    48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
                    {$urandom, $urandom}, {$urandom, $urandom}, 32'd0);
        send_noise(120);
        wait_drain();

        // largest tolerance, no idling
        idle_on = 0;
        load_planes(NEG_X, NEG_Y, NEG_Z, DIAG, {32'hFFFF_FFFF, 32'h8000_0000},
                    {32'h7FFF_FFFF, 32'hFFFF_FFFF}, 32'hFFFF_FFFF);
        send_shaped(100, 180);
        wait_drain();
        idle_on = 1;

        // extreme normal components
        load_planes({16'sh8000, 16'sh7FFF, 16'sh8000}, {16'sh7FFF, 16'sh8000, 16'sh7FFF},
                    NEG_Z, DIAG, {32'd0, 32'h8000_0000}, {32'd3783740, 32'h7FFF_FFFF},
                    32'h0000_1000);
        send_shaped(70, 180);
        send_noise(40);
        wait_drain();

        repeat (100) @(posedge clk);
        if (sb.pending.size() != 0)
            sb.report("items left with no result");
        if (sb.errors == 0)
            $display("PASS tetrahedron_point_ray_query_unit");
        else
            $display("FAIL tetrahedron_point_ray_query_unit");
        $finish;
    end

endmodule
